>>> sv/dlle_pkg.sv
// ============================================================================
// dlle_pkg - shared types and codes for the doubly linked list engine
// Request and result transaction layouts, request codes and status codes.
// ============================================================================
package dlle_pkg;

    // Fixed field widths of the transactions
    localparam int REQ_W       = 3;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int LEN_W       = 5;
    localparam int MAX_RESULTS = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [VAL_W-1:0] key_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [POS_W-1:0]        match_position;
        logic signed [VAL_W-1:0] item_value;
        logic [LEN_W-1:0]        list_length;
        logic                    last_result;
    } t_result;

endpackage

>>> sv/doubly_linked_list_engine_top.sv
// ============================================================================
// doubly_linked_list_engine_top - bounded doubly linked list engine
// Node pool of CAPACITY entries in two RAMs (values, next/prev links),
// with head, tail, length and the free-list head kept in registers.
// ============================================================================
//
//  Channel   Signals                          Transaction happens when
//  --------  -------------------------------  ------------------------------
//  request   start, busy, i_req               rising edge, start=1, busy=0
//  result    o_result_valid, o_result         every cycle o_result_valid=1
//
//  Append / insert: busy in S_NB, S_NODE, plus S_ALLOC (free-list pop) and
//  S_NBW (neighbor link update). Search, delete and dump walk one node per
//  cycle, busy for the nodes visited; delete unlinks and frees in S_DEL_N,
//  S_DEL_F. Dump results stream one per cycle. Full, empty, unused: no busy.
//  Reset (i_rst_n low, synchronous) empties the list at once: no RAM sweep.
//  The result side cannot stall; each result shows for one cycle only.
//
module doubly_linked_list_engine_top
    import dlle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_result_valid,
    output t_result o_result
);

    // Index width holds CAPACITY itself, which means "no node"
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int DUMP_LIM = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    localparam logic [IW-1:0] NIL        = IW'(CAPACITY);
    localparam logic [IW-1:0] STEP_LAST  = IW'(CAPACITY - 1);
    localparam logic [IW-1:0] DUMP_LAST  = IW'(DUMP_LIM - 1);

    typedef struct packed {
        logic [IW-1:0] nxt;
        logic [IW-1:0] prv;
    } t_link;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,    // pop the free list
        S_NB,       // read neighbor link (tail on append, head on insert)
        S_NBW,      // write neighbor link back
        S_NODE,     // write new node
        S_WALK,     // one node per cycle from head
        S_DEL_N,    // fix prev link of successor
        S_DEL_F     // push freed node on the free list
    } t_state;

    t_state                r_state, n_state;
    logic [REQ_W-1:0]      r_req, n_req;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [IW-1:0]         r_idx, n_idx;          // node being added / freed
    logic [IW-1:0]         r_cur, n_cur;          // walk position
    logic [IW-1:0]         r_steps, n_steps;
    logic [IW-1:0]         r_pred_prv, n_pred_prv; // prev link of walk predecessor
    logic [IW-1:0]         r_n, n_n;
    logic [IW-1:0]         r_p, n_p;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic [IW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_free_head, n_free_head; // freed slots, chained via next
    logic [IW-1:0]         r_fill, n_fill;        // slots never used start here
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    // RAM ports
    logic [AW-1:0]         rd_addr;
    logic                  val_we;
    logic [AW-1:0]         val_waddr;
    logic [VAL_W-1:0]      val_wdata;
    logic [VAL_W-1:0]      rd_val_raw;
    logic signed [VAL_W-1:0] rd_val;
    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    t_link                 link_wdata;
    t_link                 rd_link;

    logic [IW-1:0]         nb;
    logic                  w_match;
    logic                  w_end;
    logic                  w_last;

    function automatic t_result f_res(
        input logic [STATUS_W-1:0]     st,
        input logic [POS_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val,
        input logic [IW-1:0]           len,
        input logic                    last
    );
        t_result res;
        res.status         = st;
        res.match_position = pos;
        res.item_value     = val;
        res.list_length    = LEN_W'(len);
        res.last_result    = last;
        return res;
    endfunction

    dlle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (val_waddr),
        .i_wr_data (val_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_val_raw)
    );

    dlle_ram #(
        .WIDTH (2 * IW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (link_waddr),
        .i_wr_data (link_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_link)
    );

    assign rd_val = rd_val_raw;

    // Neighbor touched by an add: tail for append, head for insert
    assign nb      = (r_req == REQ_APPEND) ? r_tail : r_head;
    assign w_match = (rd_val == r_key);
    assign w_end   = (rd_link.nxt == NIL) || (r_steps == STEP_LAST);
    assign w_last  = w_end || (r_steps == DUMP_LAST);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_pred_prv  = r_pred_prv;
        n_n         = r_n;
        n_p         = r_p;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_free_head = r_free_head;
        n_fill      = r_fill;
        n_out_valid = 1'b0;
        n_out       = r_out;

        rd_addr     = AW'(r_cur);
        val_we      = 1'b0;
        val_waddr   = AW'(r_idx);
        val_wdata   = r_key;
        link_we     = 1'b0;
        link_waddr  = AW'(r_idx);
        link_wdata  = '{nxt: NIL, prv: NIL};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req.req_type;
                    n_key = i_req.key_value;
                    unique case (i_req.req_type) inside
                        REQ_APPEND, REQ_INSERT: begin
                            if (r_count == NIL) begin
                                n_out_valid = 1'b1;
                                n_out = f_res(ST_FULL, '0, '0, r_count, 1'b1);
                            end else if (r_free_head != NIL) begin
                                n_idx   = r_free_head;
                                rd_addr = AW'(r_free_head);
                                n_state = S_ALLOC;
                            end else begin
                                n_idx   = r_fill;
                                n_fill  = r_fill + 1'b1;
                                n_state = S_NB;
                            end
                        end
                        REQ_DELETE, REQ_SEARCH, REQ_DUMP: begin
                            if (r_head == NIL) begin
                                n_out_valid = 1'b1;
                                n_out = f_res((i_req.req_type == REQ_DUMP) ?
                                              ST_EMPTY : ST_NOT_FOUND,
                                              '0, '0, r_count, 1'b1);
                            end else begin
                                rd_addr = AW'(r_head);
                                n_cur   = r_head;
                                n_steps = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: ;  // unused codes: no result
                    endcase
                end
            end

            S_ALLOC: begin
                n_free_head = rd_link.nxt;
                n_state     = S_NB;
            end

            S_NB: begin
                rd_addr = AW'(nb);
                n_state = (nb != NIL) ? S_NBW : S_NODE;
            end

            S_NBW: begin
                link_we    = 1'b1;
                link_waddr = AW'(nb);
                if (r_req == REQ_APPEND) begin
                    link_wdata = '{nxt: r_idx, prv: rd_link.prv};
                end else begin
                    link_wdata = '{nxt: rd_link.nxt, prv: r_idx};
                end
                n_state = S_NODE;
            end

            S_NODE: begin
                val_we  = 1'b1;
                link_we = 1'b1;
                if (r_req == REQ_APPEND) begin
                    link_wdata = '{nxt: NIL, prv: r_tail};
                    if (r_tail == NIL) begin
                        n_head = r_idx;
                    end
                    n_tail = r_idx;
                end else begin
                    link_wdata = '{nxt: r_head, prv: NIL};
                    if (r_head == NIL) begin
                        n_tail = r_idx;
                    end
                    n_head = r_idx;
                end
                n_count     = r_count + 1'b1;
                n_out_valid = 1'b1;
                n_out       = f_res(ST_DONE, '0, '0, n_count, 1'b1);
                n_state     = S_IDLE;
            end

            S_WALK: begin
                case (r_req)
                    REQ_DUMP: begin
                        n_out_valid = 1'b1;
                        n_out = f_res(ST_DONE, '0, rd_val, r_count, w_last);
                        if (w_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_cur      = rd_link.nxt;
                            n_steps    = r_steps + 1'b1;
                            n_pred_prv = rd_link.prv;
                            rd_addr    = AW'(rd_link.nxt);
                        end
                    end
                    REQ_SEARCH: begin
                        if (w_match) begin
                            n_out_valid = 1'b1;
                            n_out = f_res(ST_DONE, POS_W'(r_steps), '0, r_count, 1'b1);
                            n_state = S_IDLE;
                        end else if (w_end) begin
                            n_out_valid = 1'b1;
                            n_out = f_res(ST_NOT_FOUND, '0, '0, r_count, 1'b1);
                            n_state = S_IDLE;
                        end else begin
                            n_cur      = rd_link.nxt;
                            n_steps    = r_steps + 1'b1;
                            n_pred_prv = rd_link.prv;
                            rd_addr    = AW'(rd_link.nxt);
                        end
                    end
                    default: begin
                        // delete
                        if (w_match) begin
                            // predecessor's next skips the matched node
                            if (rd_link.prv != NIL) begin
                                link_we    = 1'b1;
                                link_waddr = AW'(rd_link.prv);
                                link_wdata = '{nxt: rd_link.nxt, prv: r_pred_prv};
                            end else begin
                                n_head = rd_link.nxt;
                            end
                            rd_addr = AW'(rd_link.nxt);
                            n_idx   = r_cur;
                            n_n     = rd_link.nxt;
                            n_p     = rd_link.prv;
                            n_state = S_DEL_N;
                        end else if (w_end) begin
                            n_out_valid = 1'b1;
                            n_out = f_res(ST_NOT_FOUND, '0, '0, r_count, 1'b1);
                            n_state = S_IDLE;
                        end else begin
                            n_cur      = rd_link.nxt;
                            n_steps    = r_steps + 1'b1;
                            n_pred_prv = rd_link.prv;
                            rd_addr    = AW'(rd_link.nxt);
                        end
                    end
                endcase
            end

            S_DEL_N: begin
                if (r_n != NIL) begin
                    link_we    = 1'b1;
                    link_waddr = AW'(r_n);
                    link_wdata = '{nxt: rd_link.nxt, prv: r_p};
                end else begin
                    n_tail = r_p;
                end
                n_state = S_DEL_F;
            end

            S_DEL_F: begin
                link_we     = 1'b1;
                link_wdata  = '{nxt: r_free_head, prv: NIL};
                n_free_head = r_idx;
                n_count     = r_count - 1'b1;
                n_out_valid = 1'b1;
                n_out       = f_res(ST_DONE, '0, '0, n_count, 1'b1);
                n_state     = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_free_head <= NIL;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_req      <= n_req;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_pred_prv <= n_pred_prv;
        r_n        <= n_n;
        r_p        <= n_p;
        r_out      <= n_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

>>> sv/dlle_ram.sv
// ============================================================================
// dlle_ram - simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// Read during write to the same address returns the old contents.
// ============================================================================
module dlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/dlle_checker.sv
// ============================================================================
// dlle_checker - port-level checks for the linked list engine
// Watches the request and result ports; bound to the top level below.
// ============================================================================
module dlle_checker
    import dlle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    busy,
    input logic    o_result_valid,
    input t_result o_result
);

    // A result not marked last is always followed by another one
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last_result |=> o_result_valid)
        else $error("result run broken before last_result");

    // Engine is free again once the final result shows
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_result |-> !busy)
        else $error("busy still high on final result");

    // Mid-run results only while the request is still in work
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.last_result |-> busy)
        else $error("intermediate result while idle");

    // Empty status only on an empty list
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == ST_EMPTY |->
            o_result.list_length == '0 && o_result.last_result)
        else $error("empty status with nonzero length");

    // Length never exceeds the pool size
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (CAPACITY > MAX_RESULTS) ||
            (int'(o_result.list_length) <= CAPACITY))
        else $error("list length beyond capacity");

endmodule

bind doubly_linked_list_engine_top dlle_checker #(
    .CAPACITY (CAPACITY)
) u_dlle_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

>>> bench/tb_doubly_linked_list_engine_top.sv
// ============================================================================
// tb_doubly_linked_list_engine_top - self-checking bench for the list engine
// Drives append, insert, delete, search and dump transactions through the
// start/busy port. A bit-accurate list model in the bench predicts every
// result, and a monitor compares each strobed result, field by field, with
// the oldest prediction. A directed opening is followed by random bursts
// that fill, drain and mix.
// ============================================================================
module tb_doubly_linked_list_engine_top
    import dlle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP      = 16;   // pool size, matches the DUT default
    localparam int NIL      = CAP;  // "no node" link value
    localparam int N_RANDOM = 220;  // random requests that do real work

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_req    req_bus = '0;
    logic    o_result_valid;
    t_result o_result;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    doubly_linked_list_engine_top #(.CAPACITY(CAP)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (req_bus),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // ------------------------------------------------------------------------
    // List model: node pool with links, head/tail, free slots and length.
    // A new node always takes the lowest free slot; slot numbers never show in a result.
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] pool_val [CAP];
    int                      pool_next [CAP];
    int                      pool_prev [CAP];
    bit                      pool_free [CAP];
    int                      head_idx = NIL;
    int                      tail_idx = NIL;
    int                      list_cnt = 0;

    t_req    pending_reqs[$];       // transactions waiting for the driver
    t_result expected_results[$];   // predictions waiting for the monitor
    int      fails = 0;
    int      n_taken = 0;           // requests accepted so far
    int      n_total = 0;           // requests queued in all

    // Walks from head, bounded to CAP steps; returns the slot or NIL.
    function automatic int find_key(input logic signed [VAL_W-1:0] key,
                                    output int pos);
        int idx;
        int steps;
        idx   = head_idx;
        steps = 0;
        pos   = 0;
        while (idx < NIL && steps < CAP) begin
            if (pool_val[idx] == key) begin
                pos = steps;
                return idx;
            end
            idx = pool_next[idx];
            steps++;
        end
        return NIL;
    endfunction

    // Updates the model for one accepted transaction and queues its results.
    task automatic apply_request(input t_req r);
        int      slot;
        int      pos;
        int      p;
        int      n;
        int      k;
        t_result res;
        res  = '0;
        slot = NIL;
        res.last_result = 1'b1;
        case (r.req_type)
            REQ_APPEND, REQ_INSERT: begin
                for (int i = CAP - 1; i >= 0; i--)
                    if (pool_free[i]) slot = i;
                if (slot == NIL) begin
                    res.status = ST_FULL;
                end else begin
                    pool_free[slot] = 1'b0;
                    pool_val[slot]  = r.key_value;
                    if (r.req_type == REQ_APPEND) begin
                        pool_next[slot] = NIL;
                        pool_prev[slot] = tail_idx;
                        if (tail_idx < NIL) pool_next[tail_idx] = slot;
                        else head_idx = slot;
                        tail_idx = slot;
                    end else begin
                        pool_prev[slot] = NIL;
                        pool_next[slot] = head_idx;
                        if (head_idx < NIL) pool_prev[head_idx] = slot;
                        else tail_idx = slot;
                        head_idx = slot;
                    end
                    list_cnt++;
                    res.status = ST_DONE;
                end
                res.list_length = LEN_W'(list_cnt);
                expected_results.push_back(res);
            end
            REQ_DELETE: begin
                slot = find_key(r.key_value, pos);
                if (slot == NIL) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    p = pool_prev[slot];
                    n = pool_next[slot];
                    if (p < NIL) pool_next[p] = n;
                    else head_idx = n;
                    // deleting the only node clears tail as well as head
                    if (n < NIL) pool_prev[n] = p;
                    else tail_idx = p;
                    pool_free[slot] = 1'b1;
                    if (list_cnt > 0) list_cnt--;
                    res.status = ST_DONE;
                end
                res.list_length = LEN_W'(list_cnt);
                expected_results.push_back(res);
            end
            REQ_SEARCH: begin
                slot = find_key(r.key_value, pos);
                if (slot == NIL) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.status         = ST_DONE;
                    res.match_position = POS_W'(pos);
                end
                res.list_length = LEN_W'(list_cnt);
                expected_results.push_back(res);
            end
            REQ_DUMP: begin
                res.list_length = LEN_W'(list_cnt);
                if (head_idx >= NIL) begin
                    res.status = ST_EMPTY;
                    expected_results.push_back(res);
                end else begin
                    slot = head_idx;
                    k    = 0;
                    while (slot < NIL && k < CAP && k < MAX_RESULTS) begin
                        res.status      = ST_DONE;
                        res.item_value  = pool_val[slot];
                        slot            = pool_next[slot];
                        k++;
                        // last result of the run: end of list or the cap
                        res.last_result = !(slot < NIL && k < CAP && k < MAX_RESULTS);
                        expected_results.push_back(res);
                    end
                end
            end
            default: ; // unused codes: no result, no change
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver. Pulls the next transaction from pending_reqs when the port is
    // free; start is held high while busy. Sender idling follows the phase:
    // 23% idle for the first third, 88% for the second, none after that.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int idle_pct;
        if (!i_rst_n) begin
            start   <= 1'b0;
            req_bus <= '0;
        end else begin
            if (start && !busy) n_taken++;
            if (n_taken < n_total / 3)            idle_pct = 23;
            else if (n_taken < (2 * n_total) / 3) idle_pct = 88;
            else                                  idle_pct = 0;
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    start   <= 1'b1;
                    req_bus <= pending_reqs.pop_front();
                end else begin
                    start   <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Predicts at the accepting edge, before checking, so a result
    // that strobes right after acceptance already has its expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (start && !busy) apply_request(req_bus);
            if (o_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result with no transaction pending: %p", o_result);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_result.status);
                        fails++;
                    end
                    if (o_result.match_position !== want.match_position) begin
                        $error("match_position: expected %0d, got %0d",
                               want.match_position, o_result.match_position);
                        fails++;
                    end
                    if (o_result.item_value !== want.item_value) begin
                        $error("item_value: expected %0d, got %0d",
                               want.item_value, o_result.item_value);
                        fails++;
                    end
                    if (o_result.list_length !== want.list_length) begin
                        $error("list_length: expected %0d, got %0d",
                               want.list_length, o_result.list_length);
                        fails++;
                    end
                    if (o_result.last_result !== want.last_result) begin
                        $error("last_result: expected %0d, got %0d",
                               want.last_result, o_result.last_result);
                        fails++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. held_keys mirrors the multiset of stored values so random
    // deletes and searches mostly hit something that is really there.
    // ------------------------------------------------------------------------
    logic signed [VAL_W-1:0] held_keys[$];
    logic signed [VAL_W-1:0] hot_keys[4];

    task automatic queue_req(input logic [REQ_W-1:0] code,
                             input logic signed [VAL_W-1:0] key);
        t_req r;
        int   hit;
        r.req_type  = code;
        r.key_value = key;
        pending_reqs.push_back(r);
        n_total++;
        if ((code == REQ_APPEND || code == REQ_INSERT) && held_keys.size() < CAP)
            held_keys.push_back(key);
        if (code == REQ_DELETE) begin
            hit = -1;
            foreach (held_keys[i])
                if (hit < 0 && held_keys[i] == key) hit = i;
            if (hit >= 0) held_keys.delete(hit);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_new_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return hot_keys[$urandom_range(3)];   // duplicates
        if (roll < 35) return 32'sh8000_0000;
        if (roll < 40) return 32'sh7FFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_held_key();
        if (held_keys.size() > 0 && $urandom_range(99) < 75)
            return held_keys[$urandom_range(held_keys.size() - 1)];
        return pick_new_key();
    endfunction

    // Unused request codes sit above REQ_DUMP.
    function automatic logic [REQ_W-1:0] REQ_TYPE_UNUSED();
        return REQ_W'($urandom_range(REQ_DUMP + 1, (1 << REQ_W) - 1));
    endfunction

    initial begin
        int mode;
        int burst;
        int roll;
        int n_work;

        for (int i = 0; i < CAP; i++) pool_free[i] = 1'b1;
        hot_keys[0] = 32'sd0;
        hot_keys[1] = -32'sd1;
        hot_keys[2] = $urandom;
        hot_keys[3] = $urandom;

        // Directed opening: empty-list cases, only-node delete, extremes,
        // duplicates, head and middle deletes, unused codes.
        queue_req(REQ_DUMP,   $urandom);
        queue_req(REQ_SEARCH, 32'sd5);
        queue_req(REQ_DELETE, 32'sd5);
        queue_req(REQ_INSERT, 32'sd7);
        queue_req(REQ_DELETE, 32'sd7);
        queue_req(REQ_DUMP,   '0);
        queue_req(REQ_APPEND, 32'sh8000_0000);
        queue_req(REQ_APPEND, 32'sh7FFF_FFFF);
        queue_req(REQ_INSERT, -32'sd1);
        queue_req(REQ_APPEND, 32'sd0);
        queue_req(REQ_APPEND, -32'sd1);
        queue_req(REQ_SEARCH, -32'sd1);
        queue_req(REQ_SEARCH, 32'sd0);
        queue_req(REQ_SEARCH, 32'sd12345);
        queue_req(REQ_DUMP,   $urandom);
        queue_req(REQ_DELETE, -32'sd1);
        queue_req(REQ_DELETE, 32'sd0);
        queue_req(REQ_DELETE, 32'sh7FFF_FFFF);
        queue_req(REQ_SEARCH, -32'sd1);
        for (int c = REQ_DUMP + 1; c < (1 << REQ_W); c++)
            queue_req(REQ_W'(c), $urandom);
        queue_req(REQ_APPEND, 32'sh5A5A_A5A5);
        queue_req(REQ_DUMP,   $urandom);

        // Random bursts: fill drives the pool to full and past it, drain
        // empties it again, mix keeps it somewhere in between.
        n_work = 0;
        while (n_work < N_RANDOM) begin
            mode  = $urandom_range(2);
            burst = $urandom_range(8, 24);
            for (int j = 0; j < burst; j++) begin
                roll = $urandom_range(99);
                if (mode == 0) roll = (roll < 70) ? 0 : roll;
                else if (mode == 1) roll = (roll < 50) ? 50 : (roll < 60 ? 0 : roll);
                if (roll < 35) begin
                    queue_req($urandom_range(1) ? REQ_APPEND : REQ_INSERT, pick_new_key());
                end else if (roll < 60) begin
                    queue_req(REQ_DELETE, pick_held_key());
                end else if (roll < 80) begin
                    queue_req(REQ_SEARCH, pick_held_key());
                end else if (roll < 96) begin
                    queue_req(REQ_DUMP, $urandom);
                end else begin
                    queue_req(REQ_TYPE_UNUSED(), $urandom);
                    n_work--;   // ignored codes do no work
                end
                n_work++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent, engine idle, every prediction consumed.
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0);
        repeat (40) @(negedge i_clk);

        if (fails == 0) $display("*** PASSED ***");
        else            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
sv/dlle_pkg.sv
sv/dlle_ram.sv
sv/doubly_linked_list_engine_top.sv
sv/dlle_checker.sv
bench/tb_doubly_linked_list_engine_top.sv
